@@ src/line_line_closest_points_defines.svh @@
// assertion macros for the closest points block, used by its divider
// expects signals named clock and reset in the module that uses them
`ifndef LINE_LINE_CLOSEST_POINTS_DEFINES_SVH
`define LINE_LINE_CLOSEST_POINTS_DEFINES_SVH

// property checked at every edge outside reset
`define LLCP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("llcp assertion failed");

// property that must hold in the cycle after cond
`define LLCP_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("llcp assertion failed");

`endif

@@ src/llcp_pkg.sv @@
// types, widths and codes for the closest points between two 3d lines block
// no dependencies
package llcp_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int RESULT_FRAC_BITS = 16;

   localparam int DIFFW = COORD_WIDTH + 1;     // coordinate difference
   localparam int DOTW  = 2 * DIFFW + 2;       // three-term dot product
   localparam int PRODW = 2 * DOTW;            // product of two dot products
   localparam int DENW  = PRODW + 1;           // denominator and numerator
   localparam int QUOT_BITS = 33;              // quotient bits kept before saturation
   localparam int DIVW  = DENW + QUOT_BITS + 1;// divider remainder width
   localparam int MULW  = DOTW + 32;           // d4321 times mua
   localparam int SUMW  = MULW + 1;            // numerator of mub

   localparam int QDEPTH = 8;
   localparam int QPTRW  = $clog2(QDEPTH);
   localparam int QCNTW  = QPTRW + 1;

   localparam logic [31:0] PARALLEL_LIMIT_RESET = 32'd4295;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_B_ZERO   = 2'd1;
   localparam logic [1:0] ST_A_ZERO   = 2'd2;
   localparam logic [1:0] ST_PARALLEL = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_start_x;
      logic signed [COORD_WIDTH-1:0] a_start_y;
      logic signed [COORD_WIDTH-1:0] a_start_z;
      logic signed [COORD_WIDTH-1:0] a_end_x;
      logic signed [COORD_WIDTH-1:0] a_end_y;
      logic signed [COORD_WIDTH-1:0] a_end_z;
      logic signed [COORD_WIDTH-1:0] b_start_x;
      logic signed [COORD_WIDTH-1:0] b_start_y;
      logic signed [COORD_WIDTH-1:0] b_start_z;
      logic signed [COORD_WIDTH-1:0] b_end_x;
      logic signed [COORD_WIDTH-1:0] b_end_y;
      logic signed [COORD_WIDTH-1:0] b_end_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] param_a;
      logic signed [31:0] param_b;
      logic [1:0]         status;
   } rsp_type;

   // one queued item between front and back
   typedef struct packed {
      logic signed [DENW-1:0] den;
      logic signed [DENW-1:0] num;
      logic signed [DOTW-1:0] d1343;
      logic signed [DOTW-1:0] d4321;
      logic signed [DOTW-1:0] d4343;
      logic [1:0]             status;
   } entry_type;

   typedef struct packed {
      logic               push_valid;
      entry_type          push_entry;
   } push_type;

   typedef struct packed {
      logic [QCNTW-1:0]   count;
      logic               empty;
   } qstat_type;

   // data that rides along with a divide
   typedef struct packed {
      logic [1:0]             status;
      logic signed [31:0]     mua;
      logic signed [DOTW-1:0] d1343;
      logic signed [DOTW-1:0] d4321;
      logic signed [DOTW-1:0] d4343;
   } side_type;

endpackage

@@ src/llcp_div.sv @@
// pipelined restoring divider, one quotient bit per stage, signed saturated result
// depends on llcp_pkg and line_line_closest_points_defines.svh
`include "line_line_closest_points_defines.svh"

module llcp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [llcp_pkg::DIVW-1:0]     in_num,
   input  logic [llcp_pkg::DENW-1:0]     in_den,
   input  logic                          in_neg,
   input  llcp_pkg::side_type            in_side,
   output logic                          out_valid,
   output logic signed [31:0]            out_quot,
   output llcp_pkg::side_type            out_side
);

   localparam int QB = llcp_pkg::QUOT_BITS;

   logic [QB:0]                      vld_ff;
   logic [llcp_pkg::DIVW-1:0]        rem_ff [QB+1];
   logic [llcp_pkg::DENW-1:0]        den_ff [QB+1];
   logic [QB-1:0]                    q_ff   [QB+1];
   logic [QB:0]                      big_ff;
   logic [QB:0]                      neg_ff;
   llcp_pkg::side_type               side_ff [QB+1];
   logic [QB-1:0]                    mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   // anything at or above 2^QB is out of range already
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         q_ff[0]    <= '0;
         big_ff[0]  <= in_num >= (llcp_pkg::DIVW'(in_den) << QB);
         neg_ff[0]  <= in_neg;
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_stage
      localparam int B = QB - 1 - j;
      logic [llcp_pkg::DIVW-1:0] trial;
      logic                      ge;
      logic [llcp_pkg::DIVW-1:0] rem_in;
      logic [QB-1:0]             q_in;

      always_comb begin
         trial  = llcp_pkg::DIVW'(den_ff[j]) << B;
         ge     = rem_ff[j] >= trial;
         rem_in = ge ? rem_ff[j] - trial : rem_ff[j];
         q_in    = q_ff[j];
         q_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (en) begin
            vld_ff[j+1] <= vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= rem_in;
            den_ff[j+1]  <= den_ff[j];
            q_ff[j+1]    <= q_in;
            big_ff[j+1]  <= big_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   assign mag = q_ff[QB];

   always_comb begin
      if (neg_ff[QB]) begin
         if (big_ff[QB] || mag > QB'(33'h0_8000_0000)) begin
            out_quot = 32'sh8000_0000;
         end else begin
            out_quot = -$signed(mag[31:0]);
         end
      end else begin
         if (big_ff[QB] || mag > QB'(33'h0_7FFF_FFFF)) begin
            out_quot = 32'sh7FFF_FFFF;
         end else begin
            out_quot = $signed(mag[31:0]);
         end
      end
   end

   assign out_valid = vld_ff[QB];
   assign out_side  = side_ff[QB];

   `LLCP_ASSERT_NEXT(a_div_load, en && in_valid, vld_ff[0])
   `LLCP_ASSERT(a_div_rem, vld_ff[QB] && !big_ff[QB] && den_ff[QB] != '0 |-> rem_ff[QB] < llcp_pkg::DIVW'(den_ff[QB]))
   `LLCP_ASSERT_NEXT(a_div_hold, !en, $stable(out_valid) && $stable(out_quot))

endmodule

@@ src/llcp_front.sv @@
// front end: takes request beats, forms differences, dot products and the
// numerator and denominator of mua; depends on llcp_pkg
module llcp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  llcp_pkg::req_type    req_data,
   input  llcp_pkg::qstat_type  qstat,
   output llcp_pkg::push_type   push
);

   function automatic logic signed [llcp_pkg::DIFFW-1:0] coord_diff(
      input logic signed [llcp_pkg::COORD_WIDTH-1:0] a,
      input logic signed [llcp_pkg::COORD_WIDTH-1:0] b);
      return llcp_pkg::DIFFW'(a) - llcp_pkg::DIFFW'(b);
   endfunction

   function automatic logic signed [llcp_pkg::DOTW-1:0] dot3(
      input logic signed [llcp_pkg::DIFFW-1:0] a [3],
      input logic signed [llcp_pkg::DIFFW-1:0] b [3]);
      logic signed [llcp_pkg::DOTW-1:0] s;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         s = s + llcp_pkg::DOTW'(a[i]) * llcp_pkg::DOTW'(b[i]);
      end
      return s;
   endfunction

   logic signed [llcp_pkg::COORD_WIDTH-1:0] as [3], ae [3], bs [3], be [3];
   logic signed [llcp_pkg::DIFFW-1:0]       p13 [3], p43 [3], p21 [3];
   logic signed [llcp_pkg::DIFFW-1:0]       p13_ff [3], p43_ff [3], p21_ff [3];
   logic [1:0]                              st_in;
   logic [1:0]                              st1_ff, st2_ff, st3_ff;
   logic                                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic                                    accept;
   logic [llcp_pkg::QCNTW:0]                occupancy;

   logic signed [llcp_pkg::DOTW-1:0]  d1343_ff, d4321_ff, d1321_ff, d4343_ff, d2121_ff;
   logic signed [llcp_pkg::DOTW-1:0]  e1343_ff, e4321_ff, e4343_ff;
   logic signed [llcp_pkg::PRODW-1:0] m_aa_ff, m_ab_ff, m_na_ff, m_nb_ff;
   llcp_pkg::entry_type               entry_ff;

   // count every item already in flight so the queue never overflows
   assign occupancy = (llcp_pkg::QCNTW+1)'(qstat.count) + (llcp_pkg::QCNTW+1)'(v1_ff)
                    + (llcp_pkg::QCNTW+1)'(v2_ff) + (llcp_pkg::QCNTW+1)'(v3_ff)
                    + (llcp_pkg::QCNTW+1)'(v4_ff);
   assign req_stall = occupancy >= (llcp_pkg::QCNTW+1)'(llcp_pkg::QDEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      as = '{req_data.a_start_x, req_data.a_start_y, req_data.a_start_z};
      ae = '{req_data.a_end_x,   req_data.a_end_y,   req_data.a_end_z};
      bs = '{req_data.b_start_x, req_data.b_start_y, req_data.b_start_z};
      be = '{req_data.b_end_x,   req_data.b_end_y,   req_data.b_end_z};
      for (int i = 0; i < 3; i++) begin
         p13[i] = coord_diff(as[i], bs[i]);
         p43[i] = coord_diff(be[i], bs[i]);
         p21[i] = coord_diff(ae[i], as[i]);
      end
      // line b is checked first
      if (p43[0] == '0 && p43[1] == '0 && p43[2] == '0) begin
         st_in = llcp_pkg::ST_B_ZERO;
      end else if (p21[0] == '0 && p21[1] == '0 && p21[2] == '0) begin
         st_in = llcp_pkg::ST_A_ZERO;
      end else begin
         st_in = llcp_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      p13_ff <= p13;
      p43_ff <= p43;
      p21_ff <= p21;
      st1_ff <= st_in;

      d1343_ff <= dot3(p13_ff, p43_ff);
      d4321_ff <= dot3(p43_ff, p21_ff);
      d1321_ff <= dot3(p13_ff, p21_ff);
      d4343_ff <= dot3(p43_ff, p43_ff);
      d2121_ff <= dot3(p21_ff, p21_ff);
      st2_ff   <= st1_ff;

      m_aa_ff  <= d2121_ff * d4343_ff;
      m_ab_ff  <= d4321_ff * d4321_ff;
      m_na_ff  <= d1343_ff * d4321_ff;
      m_nb_ff  <= d1321_ff * d4343_ff;
      e1343_ff <= d1343_ff;
      e4321_ff <= d4321_ff;
      e4343_ff <= d4343_ff;
      st3_ff   <= st2_ff;

      entry_ff.den    <= llcp_pkg::DENW'(m_aa_ff) - llcp_pkg::DENW'(m_ab_ff);
      entry_ff.num    <= llcp_pkg::DENW'(m_na_ff) - llcp_pkg::DENW'(m_nb_ff);
      entry_ff.d1343  <= e1343_ff;
      entry_ff.d4321  <= e4321_ff;
      entry_ff.d4343  <= e4343_ff;
      entry_ff.status <= st3_ff;
   end

   assign push.push_valid = v4_ff;
   assign push.push_entry = entry_ff;

endmodule

@@ src/llcp_queue.sv @@
// short queue that parts the front end from the divide back end
// depends on llcp_pkg
module llcp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  llcp_pkg::push_type   push,
   input  logic                 pop,
   output llcp_pkg::entry_type  head,
   output llcp_pkg::qstat_type  qstat
);

   llcp_pkg::entry_type        mem [llcp_pkg::QDEPTH];
   logic [llcp_pkg::QPTRW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [llcp_pkg::QPTRW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [llcp_pkg::QCNTW-1:0] count_ff, count_in;
   logic                       do_pop;

   assign do_pop = pop && count_ff != '0;

   always_comb begin
      wr_ptr_in = push.push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + llcp_pkg::QCNTW'(push.push_valid) - llcp_pkg::QCNTW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_valid) begin
         mem[wr_ptr_ff] <= push.push_entry;
      end
   end

   assign head        = mem[rd_ptr_ff];
   assign qstat.count = count_ff;
   assign qstat.empty = count_ff == '0;

endmodule

@@ src/llcp_back.sv @@
// back end: parallel test, divide for mua, product and divide for mub,
// response register; depends on llcp_pkg and llcp_div
module llcp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   input  llcp_pkg::entry_type  head,
   input  llcp_pkg::qstat_type  qstat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output llcp_pkg::rsp_type    rsp_data
);

   logic                          en;
   logic [31:0]                   limit_ff;
   logic [llcp_pkg::DENW-1:0]     den_abs, num_abs;
   logic                          parallel;

   logic                          b0_vld_ff;
   logic [llcp_pkg::DIVW-1:0]     b0_nmag_ff;
   logic [llcp_pkg::DENW-1:0]     b0_dmag_ff;
   logic                          b0_neg_ff;
   llcp_pkg::side_type            b0_side_ff, b0_side_in;

   logic                          d1_vld;
   logic signed [31:0]            d1_quot;
   llcp_pkg::side_type            d1_side;

   logic                          b1_vld_ff, b2_vld_ff, b3_vld_ff, b4_vld_ff;
   llcp_pkg::side_type            b1_side_ff, b2_side_ff, b3_side_ff, b4_side_ff;
   llcp_pkg::side_type            b1_side_in;
   logic signed [llcp_pkg::MULW-1:0] b2_prod_ff;
   logic signed [llcp_pkg::SUMW-1:0] b3_sum_ff;
   logic [llcp_pkg::SUMW-1:0]     sum_abs;
   logic [llcp_pkg::DIVW-1:0]     b4_nmag_ff;
   logic [llcp_pkg::DENW-1:0]     b4_dmag_ff;
   logic                          b4_neg_ff;

   logic                          d2_vld;
   logic signed [31:0]            d2_quot;
   llcp_pkg::side_type            d2_side;

   logic                          rsp_valid_ff;
   llcp_pkg::rsp_type             rsp_data_ff;

   // whole back end freezes while a response beat waits
   assign en  = !(rsp_valid_ff && rsp_stall);
   assign pop = en && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= llcp_pkg::PARALLEL_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_comb begin
      den_abs  = head.den[llcp_pkg::DENW-1] ? $unsigned(-head.den) : $unsigned(head.den);
      num_abs  = head.num[llcp_pkg::DENW-1] ? $unsigned(-head.num) : $unsigned(head.num);
      // zero counts as parallel even with a zero limit
      parallel = head.den == '0 || den_abs < llcp_pkg::DENW'(limit_ff);
      b0_side_in.status = (head.status == llcp_pkg::ST_OK && parallel) ?
                          llcp_pkg::ST_PARALLEL : head.status;
      b0_side_in.mua    = '0;
      b0_side_in.d1343  = head.d1343;
      b0_side_in.d4321  = head.d4321;
      b0_side_in.d4343  = head.d4343;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_vld_ff    <= 1'b0;
         b1_vld_ff    <= 1'b0;
         b2_vld_ff    <= 1'b0;
         b3_vld_ff    <= 1'b0;
         b4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b0_vld_ff    <= pop;
         b1_vld_ff    <= d1_vld;
         b2_vld_ff    <= b1_vld_ff;
         b3_vld_ff    <= b2_vld_ff;
         b4_vld_ff    <= b3_vld_ff;
         rsp_valid_ff <= d2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b0_nmag_ff <= llcp_pkg::DIVW'(num_abs) << llcp_pkg::RESULT_FRAC_BITS;
         b0_dmag_ff <= den_abs;
         b0_neg_ff  <= head.num[llcp_pkg::DENW-1] ^ head.den[llcp_pkg::DENW-1];
         b0_side_ff <= b0_side_in;
      end
   end

   llcp_div u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b0_vld_ff),
      .in_num    (b0_nmag_ff),
      .in_den    (b0_dmag_ff),
      .in_neg    (b0_neg_ff),
      .in_side   (b0_side_ff),
      .out_valid (d1_vld),
      .out_quot  (d1_quot),
      .out_side  (d1_side)
   );

   assign sum_abs = b3_sum_ff[llcp_pkg::SUMW-1] ? $unsigned(-b3_sum_ff) : $unsigned(b3_sum_ff);

   always_comb begin
      b1_side_in     = d1_side;
      b1_side_in.mua = d1_quot;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_side_ff <= b1_side_in;

         b2_prod_ff <= b1_side_ff.d4321 * b1_side_ff.mua;
         b2_side_ff <= b1_side_ff;

         b3_sum_ff  <= (llcp_pkg::SUMW'(b2_side_ff.d1343) <<< llcp_pkg::RESULT_FRAC_BITS)
                     + llcp_pkg::SUMW'(b2_prod_ff);
         b3_side_ff <= b2_side_ff;

         // d4343 is positive whenever the result is used
         b4_nmag_ff <= llcp_pkg::DIVW'(sum_abs);
         b4_dmag_ff <= llcp_pkg::DENW'($unsigned(b3_side_ff.d4343));
         b4_neg_ff  <= b3_sum_ff[llcp_pkg::SUMW-1];
         b4_side_ff <= b3_side_ff;
      end
   end

   llcp_div u_div_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b4_vld_ff),
      .in_num    (b4_nmag_ff),
      .in_den    (b4_dmag_ff),
      .in_neg    (b4_neg_ff),
      .in_side   (b4_side_ff),
      .out_valid (d2_vld),
      .out_quot  (d2_quot),
      .out_side  (d2_side)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.status <= d2_side.status;
         if (d2_side.status == llcp_pkg::ST_OK) begin
            rsp_data_ff.param_a <= d2_side.mua;
            rsp_data_ff.param_b <= d2_quot;
         end else begin
            rsp_data_ff.param_a <= '0;
            rsp_data_ff.param_b <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/line_line_closest_points.sv @@
// Closest points between two 3D lines. Each request beat carries two lines as
// four Q8.8 points; each response beat returns the line parameters of the
// mutually closest points in Q16.16 (truncated toward zero, saturated) and a
// status: ok, second line zero length, first line zero length, or parallel,
// all but ok giving zero parameters. One beat is taken every clock while
// req_stall is low; beats pass front end products, a short queue and two
// bit-per-stage dividers. The parallel limit register, reset 4295, is written
// through csr_wr_en and csr_wr_data; the user must write it only while idle,
// which is not enforced. Top level; uses llcp_pkg, llcp_front, llcp_queue, llcp_back
module line_line_closest_points (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  llcp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output llcp_pkg::rsp_type  rsp_data,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);

   llcp_pkg::push_type   push;
   llcp_pkg::qstat_type  qstat;
   llcp_pkg::entry_type  head;
   logic                 pop;

   llcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push)
   );

   llcp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   llcp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
